[src/ssrm_pkg.sv]
// Shared constants, codes and the result word layout for the slot pool manager.
`timescale 1ns / 1ps

package ssrm_pkg;

   localparam int SLOTS_DEF      = 8;
   localparam int COUNT_BITS_DEF = 16;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REQ_DATA_BITS  = 48;
   localparam int RSP_DATA_BITS  = 80;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOTS_IN_USE   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_GEN    = 1'd1;

   localparam logic [2:0] CMD_INIT    = 3'd0;
   localparam logic [2:0] CMD_PIN     = 3'd1;
   localparam logic [2:0] CMD_UNPIN   = 3'd2;
   localparam logic [2:0] CMD_PREPARE = 3'd3;
   localparam logic [2:0] CMD_PUBLISH = 3'd4;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NULL_HANDLE  = 3'd1;
   localparam logic [2:0] ST_NO_FREE      = 3'd2;
   localparam logic [2:0] ST_GEN_EXHAUSTED = 3'd3;
   localparam logic [2:0] ST_BAD_SLOT     = 3'd4;
   localparam logic [2:0] ST_COUNT_ZERO   = 3'd5;
   localparam logic [2:0] ST_NOT_PREPARED = 3'd6;
   localparam logic [2:0] ST_COUNT_FULL   = 3'd7;

   localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]  freed_slot;
      logic        freed;
      logic [31:0] result_handle;
      logic [31:0] generation;
      logic [2:0]  result_slot;
      logic [2:0]  status;
   } rsp_type;

endpackage

[src/ssrm_ram.sv]
// Generic synchronous RAM: one write port, two read ports with registered data.
`timescale 1ns / 1ps

module ssrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

[src/snapshot_slot_refcount_manager_core.sv]
// Top level of the slot pool manager: command decode, read-modify-write and result register.
`timescale 1ns / 1ps
// An accepted word is held in the s1 register, its slot memory read is registered,
// and its read-modify-write runs once the result register is free; no new word is
// taken while one is held in s1.
// Reset is synchronous and clears the pool like an init with a null base handle; per-slot valid bits
// stand for the cleared pool, so there is no clearing pass.

module snapshot_slot_refcount_manager_core #(
   parameter int SLOTS      = ssrm_pkg::SLOTS_DEF,
   parameter int COUNT_BITS = ssrm_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // command[2:0], slot[10:3], graph_handle[42:11], zero pad
   input  logic [ssrm_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[2:0], result_slot[5:3], generation[37:6], result_handle[69:38],
   // freed[70], freed_slot[73:71], zero pad
   output logic [ssrm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [ssrm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ssrm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int DEPTH_BITS = $clog2(SLOTS + 1);
   localparam int REC_BITS   = COUNT_BITS + 64;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [DEPTH_BITS-1:0] RESET_DEPTH =
      DEPTH_BITS'((SLOTS < 8 ? SLOTS : 8) - 1);
   localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = DEPTH_BITS'(SLOTS);

   logic [3:0]            slots_in_use_ff;
   logic [31:0]           init_gen_ff;
   logic [SLOT_BITS-1:0]  current_ff, current_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [31:0]           last_gen_ff, last_gen_in;
   logic [31:0]           base_handle_ff, base_handle_in;
   logic [31:0]           base_gen_ff, base_gen_in;
   logic [SLOTS-1:0]      slot_valid_ff, slot_valid_in;
   logic [SLOTS-1:0]      stack_valid_ff, stack_valid_in;

   logic                  s1_valid_ff;
   logic [2:0]            s1_cmd_ff;
   logic [7:0]            s1_slot_ff;
   logic [31:0]           s1_handle_ff;

   ssrm_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rsp_tvalid_ff;

   logic                  accept;
   logic                  exec;
   logic [2:0]            req_cmd;
   logic [7:0]            req_slot;
   logic [31:0]           req_handle;
   logic [3:0]            n_used;
   logic [SLOT_BITS-1:0]  req_a_idx;
   logic [SLOT_BITS-1:0]  a_idx;
   logic [SLOT_BITS-1:0]  top_idx;
   logic [DEPTH_BITS-1:0] depth_m1;

   logic [REC_BITS-1:0]   ram_a, ram_b, rec_a, rec_b;
   logic [SLOT_BITS-1:0]  stack_rd, stack_top;
   logic [COUNT_BITS-1:0] cnt_a, cnt_b;
   logic [31:0]           hdl_a, gen_a;
   logic                  bad_slot;

   logic                  slot_wr_en;
   logic [SLOT_BITS-1:0]  slot_wr_addr;
   logic [REC_BITS-1:0]   slot_wr_data;
   logic                  stack_wr_en;
   logic [SLOT_BITS-1:0]  stack_wr_addr;
   logic [SLOT_BITS-1:0]  stack_wr_data;

   assign req_cmd    = req_tdata[2:0];
   assign req_slot   = req_tdata[10:3];
   assign req_handle = req_tdata[42:11];

   assign req_tready = !s1_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign exec       = s1_valid_ff && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      if (slots_in_use_ff < 4'd2) begin
         n_used = 4'd2;
      end else if (32'(slots_in_use_ff) > SLOTS) begin
         n_used = 4'(SLOTS);
      end else begin
         n_used = slots_in_use_ff;
      end
   end

   assign req_a_idx = (req_cmd == ssrm_pkg::CMD_PIN) ? current_ff : req_slot[SLOT_BITS-1:0];
   assign a_idx     = (s1_cmd_ff == ssrm_pkg::CMD_PIN) ? current_ff : s1_slot_ff[SLOT_BITS-1:0];
   assign depth_m1  = depth_ff - DEPTH_BITS'(1);
   assign top_idx   = depth_m1[SLOT_BITS-1:0];

   ssrm_ram #(
      .WIDTH (REC_BITS),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock     (clock),
      .wr_en     (slot_wr_en),
      .wr_addr   (slot_wr_addr),
      .wr_data   (slot_wr_data),
      .rd_en     (accept),
      .rd_addr_a (req_a_idx),
      .rd_addr_b (current_ff),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   ssrm_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (SLOTS)
   ) u_stack_ram (
      .clock     (clock),
      .wr_en     (stack_wr_en),
      .wr_addr   (stack_wr_addr),
      .wr_data   (stack_wr_data),
      .rd_en     (accept),
      .rd_addr_a (top_idx),
      .rd_addr_b ('0),
      .rd_data_a (stack_rd),
      .rd_data_b ()
   );

   always_comb begin
      if (slot_valid_ff[a_idx]) begin
         rec_a = ram_a;
      end else if (a_idx == '0) begin
         rec_a = {COUNT_BITS'(1), base_handle_ff, base_gen_ff};
      end else begin
         rec_a = '0;
      end
      if (slot_valid_ff[current_ff]) begin
         rec_b = ram_b;
      end else if (current_ff == '0) begin
         rec_b = {COUNT_BITS'(1), base_handle_ff, base_gen_ff};
      end else begin
         rec_b = '0;
      end
      stack_top = stack_valid_ff[top_idx] ? stack_rd : SLOT_BITS'(top_idx + 1);
   end

   assign cnt_a    = rec_a[REC_BITS-1 -: COUNT_BITS];
   assign hdl_a    = rec_a[63:32];
   assign gen_a    = rec_a[31:0];
   assign cnt_b    = rec_b[REC_BITS-1 -: COUNT_BITS];
   assign bad_slot = s1_slot_ff >= 8'(n_used);

   always_comb begin
      rsp_in         = '0;
      current_in     = current_ff;
      depth_in       = depth_ff;
      last_gen_in    = last_gen_ff;
      base_handle_in = base_handle_ff;
      base_gen_in    = base_gen_ff;
      slot_valid_in  = slot_valid_ff;
      stack_valid_in = stack_valid_ff;
      slot_wr_en     = 1'b0;
      slot_wr_addr   = a_idx;
      slot_wr_data   = rec_a;
      stack_wr_en    = 1'b0;
      stack_wr_addr  = depth_ff[SLOT_BITS-1:0];
      stack_wr_data  = a_idx;
      unique case (s1_cmd_ff)
         ssrm_pkg::CMD_INIT: begin
            if (s1_handle_ff == '0) begin
               rsp_in.status = ssrm_pkg::ST_NULL_HANDLE;
            end else begin
               slot_valid_in     = '0;
               stack_valid_in    = '0;
               base_handle_in    = s1_handle_ff;
               base_gen_in       = init_gen_ff;
               last_gen_in       = init_gen_ff;
               current_in        = '0;
               depth_in          = DEPTH_BITS'(n_used) - DEPTH_BITS'(1);
               rsp_in.generation = init_gen_ff;
            end
         end
         ssrm_pkg::CMD_PIN: begin
            rsp_in.result_slot = 3'(current_ff);
            if (cnt_a == '0) begin
               rsp_in.status = ssrm_pkg::ST_COUNT_ZERO;
            end else if (cnt_a == COUNT_MAX) begin
               rsp_in.status = ssrm_pkg::ST_COUNT_FULL;
            end else begin
               slot_wr_en           = 1'b1;
               slot_wr_data         = {cnt_a + COUNT_BITS'(1), hdl_a, gen_a};
               rsp_in.generation    = gen_a;
               rsp_in.result_handle = hdl_a;
            end
         end
         ssrm_pkg::CMD_UNPIN: begin
            rsp_in.result_slot = s1_slot_ff[2:0];
            if (bad_slot) begin
               rsp_in.status = ssrm_pkg::ST_BAD_SLOT;
            end else if (cnt_a == '0) begin
               rsp_in.status = ssrm_pkg::ST_COUNT_ZERO;
            end else begin
               slot_wr_en = 1'b1;
               if (cnt_a == COUNT_BITS'(1) && a_idx != current_ff) begin
                  slot_wr_data      = '0;
                  rsp_in.freed      = 1'b1;
                  rsp_in.freed_slot = 3'(a_idx);
                  if (depth_ff < DEPTH_FULL) begin
                     stack_wr_en                  = 1'b1;
                     stack_valid_in[stack_wr_addr] = 1'b1;
                     depth_in                     = depth_ff + DEPTH_BITS'(1);
                  end
               end else begin
                  slot_wr_data = {cnt_a - COUNT_BITS'(1), hdl_a, gen_a};
               end
            end
         end
         ssrm_pkg::CMD_PREPARE: begin
            if (s1_handle_ff == '0) begin
               rsp_in.status = ssrm_pkg::ST_NULL_HANDLE;
            end else if (depth_ff == '0) begin
               rsp_in.status = ssrm_pkg::ST_NO_FREE;
            end else if (last_gen_ff == ssrm_pkg::GEN_MAX) begin
               rsp_in.status = ssrm_pkg::ST_GEN_EXHAUSTED;
            end else begin
               depth_in           = depth_m1;
               last_gen_in        = last_gen_ff + 32'd1;
               slot_wr_en         = 1'b1;
               slot_wr_addr       = stack_top;
               slot_wr_data       = {COUNT_BITS'(1), s1_handle_ff, last_gen_ff + 32'd1};
               rsp_in.result_slot = 3'(stack_top);
               rsp_in.generation  = last_gen_ff + 32'd1;
            end
         end
         ssrm_pkg::CMD_PUBLISH: begin
            rsp_in.result_slot = s1_slot_ff[2:0];
            if (bad_slot) begin
               rsp_in.status = ssrm_pkg::ST_BAD_SLOT;
            end else if (cnt_a == '0) begin
               rsp_in.status = ssrm_pkg::ST_NOT_PREPARED;
            end else begin
               rsp_in.generation = gen_a;
               current_in        = a_idx;
               slot_wr_addr      = current_ff;
               if (a_idx == current_ff) begin
                  slot_wr_en   = 1'b1;
                  slot_wr_data = {cnt_a - COUNT_BITS'(1), hdl_a, gen_a};
               end else if (cnt_b != '0) begin
                  slot_wr_en = 1'b1;
                  if (cnt_b == COUNT_BITS'(1)) begin
                     slot_wr_data      = '0;
                     stack_wr_data     = current_ff;
                     rsp_in.freed      = 1'b1;
                     rsp_in.freed_slot = 3'(current_ff);
                     if (depth_ff < DEPTH_FULL) begin
                        stack_wr_en                  = 1'b1;
                        stack_valid_in[stack_wr_addr] = 1'b1;
                        depth_in                     = depth_ff + DEPTH_BITS'(1);
                     end
                  end else begin
                     slot_wr_data = {cnt_b - COUNT_BITS'(1), rec_b[63:0]};
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (slot_wr_en) begin
         slot_valid_in[slot_wr_addr] = 1'b1;
      end
      slot_wr_en  = slot_wr_en && exec;
      stack_wr_en = stack_wr_en && exec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= 4'd8;
         init_gen_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ssrm_pkg::CSR_SLOTS_IN_USE: slots_in_use_ff <= csr_wdata[3:0];
            ssrm_pkg::CSR_INITIAL_GEN:  init_gen_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff     <= '0;
         depth_ff       <= RESET_DEPTH;
         last_gen_ff    <= '0;
         base_handle_ff <= '0;
         base_gen_ff    <= '0;
         slot_valid_ff  <= '0;
         stack_valid_ff <= '0;
      end else if (exec) begin
         current_ff     <= current_in;
         depth_ff       <= depth_in;
         last_gen_ff    <= last_gen_in;
         base_handle_ff <= base_handle_in;
         base_gen_ff    <= base_gen_in;
         slot_valid_ff  <= slot_valid_in;
         stack_valid_ff <= stack_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (exec) begin
            s1_valid_ff <= 1'b0;
         end
         if (exec) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= req_cmd;
         s1_slot_ff   <= req_slot;
         s1_handle_ff <= req_handle;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff};

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_FULL)
      else $error("free stack depth beyond pool size");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(accept && exec))
      else $error("word accepted while a command executes");

   a_prepare_pop: assert property (@(posedge clock) disable iff (reset)
      exec && s1_cmd_ff == ssrm_pkg::CMD_PREPARE && rsp_in.status == ssrm_pkg::ST_OK
      |=> depth_ff == DEPTH_BITS'($past(depth_ff) - DEPTH_BITS'(1)))
      else $error("prepare did not pop the free stack");

   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      exec && s1_cmd_ff == ssrm_pkg::CMD_INIT && rsp_in.status == ssrm_pkg::ST_OK
      |=> slot_valid_ff == '0 && current_ff == '0)
      else $error("init left stale slot state");
`endif

endmodule
